FILE: src/lsps_pkg.sv
// Shared constants, types and helpers for the line sensor PD steering block.
package lsps_pkg;

  localparam int unsigned MedianTaps = 5;
  localparam int unsigned TapW       = $clog2(MedianTaps);
  localparam int unsigned CntW       = $clog2(MedianTaps + 1);
  localparam int unsigned MedK       = (MedianTaps - 1) / 2;

  localparam int unsigned DivW       = 13;
  localparam int unsigned DvsW       = 4;
  // ceil(2^32 / 25): (x * Recip25) >> 32 == x / 25 for x < 2^30
  localparam logic [27:0] Recip25    = 28'd171798692;

  typedef enum logic [2:0] {
    REG_CENTER  = 3'd0,
    REG_MIN     = 3'd1,
    REG_MAX     = 3'd2,
    REG_OUTER   = 3'd3,
    REG_INNER   = 3'd4,
    REG_PGAIN   = 3'd5,
    REG_DGAIN   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MED,
    OP_WSUM,
    OP_DIV1,
    OP_TGT,
    OP_MULP,
    OP_MULD,
    OP_USUM,
    OP_ACC,
    OP_DIV2,
    OP_PWM,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [TapW-1:0] med_idx;
    logic            take;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic div_busy;
    logic out_full;
  } sts_t;

  function automatic logic [11:0] clamp_pulse(input logic signed [24:0] v,
                                              input logic [11:0] lo,
                                              input logic [11:0] hi);
    logic signed [24:0] r;
    r = v;
    if (r > $signed({13'd0, hi})) r = $signed({13'd0, hi});
    if (r < $signed({13'd0, lo})) r = $signed({13'd0, lo});
    return r[11:0];
  endfunction

endpackage

FILE: src/lsps_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned magnitudes.
module lsps_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [lsps_pkg::DivW-1:0] dividend_i,
  input  logic [lsps_pkg::DvsW-1:0] divisor_i,
  output logic [lsps_pkg::DivW-1:0] quo_o,
  output logic                    busy_o
);
  import lsps_pkg::*;

  localparam int unsigned CW = $clog2(DivW);

  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic [DvsW:0]   trial, diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DivW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign busy_o = busy_q;
endmodule

FILE: src/lsps_dp.sv
// Datapath: config registers, window/median store, target and PD arithmetic.
module lsps_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsps_pkg::cmd_t    cmd_i,
  output lsps_pkg::sts_t    sts_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [11:0]       cfg_data_i,
  input  logic [7:0]        sensor_bits_i,
  input  logic              window_end_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [11:0]       servo_pulse_o,
  output logic [11:0]       target_pulse_o,
  output logic              line_seen_o
);
  import lsps_pkg::*;

  logic [11:0] center_q, pmin_q, pmax_q;
  logic [9:0]  outer_q, inner_q;
  logic [7:0]  kp_q, kd_q;

  logic [7:0]      win_q;
  logic [7:0]      store_q [MedianTaps];
  logic [TapW-1:0] idx_q;
  logic [7:0]      med_q;

  logic signed [12:0] weight_q;
  logic [3:0]         n_q;
  logic               neg_q;
  logic [11:0]        held_q, tgt_q, pwm_q;
  logic signed [12:0] e_q, pe_q;
  logic signed [13:0] diff_q;
  logic signed [21:0] p_q;
  logic signed [22:0] dm_q;
  logic signed [23:0] u_q;
  logic signed [23:0] h_q [3];
  logic signed [30:0] acc_q;
  logic [23:0]        q100_q;
  logic               seen_q, mval_q;

  logic [7:0]        cand, dark;
  logic [CntW-1:0]   less_c, le_c;
  logic [2:0]        no, ni;
  logic              div_start;
  logic [DivW-1:0]   div_dvd, quo;
  logic [DvsW-1:0]   div_dvs;
  logic              div_busy;
  logic [12:0]       wmag;
  logic [29:0]       amag;
  logic [55:0]       qprod;
  logic signed [13:0] qs;
  logic signed [14:0] traw;
  logic [11:0]       tclamp;
  logic signed [23:0] s;
  logic signed [24:0] praw;
  logic signed [30:0] acc_d;

  always_comb begin
    cand   = store_q[cmd_i.med_idx];
    less_c = '0;
    le_c   = '0;
    for (int j = 0; j < MedianTaps; j++) begin
      less_c = less_c + CntW'(store_q[j] < cand);
      le_c   = le_c + CntW'(store_q[j] <= cand);
    end
  end

  assign dark = ~med_q;
  assign no = 3'(dark[7]) + 3'(dark[6]) + 3'(dark[3]) + 3'(dark[2]);
  assign ni = 3'(dark[5]) + 3'(dark[4]) + 3'(dark[1]) + 3'(dark[0]);

  assign wmag = weight_q[12] ? 13'(-weight_q) : 13'(weight_q);
  assign amag = acc_q[30] ? 30'(-acc_q) : 30'(acc_q);
  // divide by 100 as (x >> 2) / 25
  assign qprod = 56'(amag[29:2]) * 56'(Recip25);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd_i.op)
      OP_DIV1: begin
        div_start = 1'b1;
        div_dvd   = DivW'(wmag);
        div_dvs   = DvsW'(n_q);
      end
      default: ;
    endcase
  end

  lsps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quo_o      (quo),
    .busy_o     (div_busy)
  );

  assign qs     = neg_q ? -$signed({1'b0, quo[12:0]}) : $signed({1'b0, quo[12:0]});
  assign traw   = (n_q != 4'd0) ? $signed({3'b0, center_q}) - 15'(qs)
                                : $signed({3'b0, held_q});
  assign tclamp = clamp_pulse(25'(traw), pmin_q, pmax_q);
  assign s      = neg_q ? -$signed(q100_q) : $signed(q100_q);
  assign praw   = $signed({13'd0, center_q}) - 25'(s);
  assign acc_d  = 31'(u_q) * 31'sd85 + 31'(h_q[0]) * 31'sd8
                + 31'(h_q[1]) * 31'sd5 + 31'(h_q[2]) * 31'sd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 12'd1210;
      pmin_q   <= 12'd850;
      pmax_q   <= 12'd1600;
      outer_q  <= 10'd400;
      inner_q  <= 10'd300;
      kp_q     <= 8'd1;
      kd_q     <= 8'd1;
      win_q    <= 8'hff;
      idx_q    <= '0;
      held_q   <= '0;
      pe_q     <= '0;
      h_q[0]   <= '0;
      h_q[1]   <= '0;
      h_q[2]   <= '0;
      mval_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER: center_q <= cfg_data_i;
          REG_MIN:    pmin_q   <= cfg_data_i;
          REG_MAX:    pmax_q   <= cfg_data_i;
          REG_OUTER:  outer_q  <= cfg_data_i[9:0];
          REG_INNER:  inner_q  <= cfg_data_i[9:0];
          REG_PGAIN:  kp_q     <= cfg_data_i[7:0];
          REG_DGAIN:  kd_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        if (window_end_i) begin
          win_q <= 8'hff;
          idx_q <= (idx_q == TapW'(MedianTaps - 1)) ? '0 : idx_q + 1'b1;
        end else begin
          win_q <= win_q & sensor_bits_i;
        end
      end
      if (cmd_i.op == OP_TGT) held_q <= tclamp;
      if (cmd_i.op == OP_MULP) pe_q <= e_q;
      if (cmd_i.op == OP_ACC) begin
        h_q[0] <= u_q;
        h_q[1] <= h_q[0];
        h_q[2] <= h_q[1];
      end
      if (cmd_i.op == OP_OUT) mval_q <= 1'b1;
      else if (m_ready_i) mval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && window_end_i) store_q[idx_q] <= win_q & sensor_bits_i;
    case (cmd_i.op)
      OP_MED:  if (less_c <= CntW'(MedK) && le_c > CntW'(MedK)) med_q <= cand;
      OP_WSUM: begin
        weight_q <= $signed({1'b0, 12'(outer_q * no)}) - $signed({1'b0, 12'(inner_q * ni)});
        n_q      <= 4'(no) + 4'(ni);
      end
      OP_DIV1: neg_q <= weight_q[12];
      OP_TGT: begin
        tgt_q  <= tclamp;
        e_q    <= $signed({1'b0, tclamp}) - $signed({1'b0, center_q});
        seen_q <= n_q != 4'd0;
      end
      OP_MULP: begin
        p_q    <= $signed({1'b0, kp_q}) * e_q;
        diff_q <= 14'(e_q) - 14'(pe_q);
      end
      OP_MULD: dm_q  <= $signed({1'b0, kd_q}) * diff_q;
      OP_USUM: u_q   <= 24'(p_q) + 24'(dm_q);
      OP_ACC:  acc_q <= acc_d;
      OP_DIV2: begin
        neg_q  <= acc_q[30];
        q100_q <= qprod[55:32];
      end
      OP_PWM:  pwm_q <= clamp_pulse(praw, pmin_q, pmax_q);
      OP_OUT: begin
        servo_pulse_o  <= pwm_q;
        target_pulse_o <= tgt_q;
        line_seen_o    <= seen_q;
      end
      default: ;
    endcase
  end

  assign m_valid_o      = mval_q;
  assign sts_o.last_tap = idx_q == TapW'(MedianTaps - 1);
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_full = mval_q && !m_ready_i;
endmodule

FILE: src/lsps_ctrl.sv
// Controller: sequences median search, divisions, PD update and output load.
module lsps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  lsps_pkg::sts_t sts_i,
  output lsps_pkg::cmd_t cmd_o
);
  import lsps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MED, S_WSUM, S_DIV1, S_WAIT1, S_TGT, S_MULP, S_MULD,
    S_USUM, S_ACC, S_DIV2, S_PWM, S_OUT
  } state_e;

  state_e          state_q;
  logic [TapW-1:0] med_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      med_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i && in_last_i && sts_i.last_tap) begin
          state_q <= S_MED;
          med_q   <= '0;
        end
        S_MED: begin
          med_q <= med_q + 1'b1;
          if (med_q == TapW'(MedianTaps - 1)) state_q <= S_WSUM;
        end
        S_WSUM:  state_q <= S_DIV1;
        S_DIV1:  state_q <= S_WAIT1;
        S_WAIT1: if (!sts_i.div_busy) state_q <= S_TGT;
        S_TGT:   state_q <= S_MULP;
        S_MULP:  state_q <= S_MULD;
        S_MULD:  state_q <= S_USUM;
        S_USUM:  state_q <= S_ACC;
        S_ACC:   state_q <= S_DIV2;
        S_DIV2:  state_q <= S_PWM;
        S_PWM:   state_q <= S_OUT;
        S_OUT:   if (!sts_i.out_full) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = state_q == S_IDLE;
  assign cmd_o.take     = in_ready_o && in_valid_i;
  assign cmd_o.med_idx  = med_q;

  always_comb begin
    case (state_q)
      S_MED:   cmd_o.op = OP_MED;
      S_WSUM:  cmd_o.op = OP_WSUM;
      S_DIV1:  cmd_o.op = OP_DIV1;
      S_TGT:   cmd_o.op = OP_TGT;
      S_MULP:  cmd_o.op = OP_MULP;
      S_MULD:  cmd_o.op = OP_MULD;
      S_USUM:  cmd_o.op = OP_USUM;
      S_ACC:   cmd_o.op = OP_ACC;
      S_DIV2:  cmd_o.op = OP_DIV2;
      S_PWM:   cmd_o.op = OP_PWM;
      S_OUT:   cmd_o.op = sts_i.out_full ? OP_IDLE : OP_OUT;
      default: cmd_o.op = OP_IDLE;
    endcase
  end
endmodule

FILE: src/line_sensor_pd_steering.sv
// Top level of the line sensor PD steering block.
// Only a word that closes the fifth window starts an evaluation: 5 median
// steps, 1 weight step, a serial divide by the dark count, then 8 PD/output
// steps. Input is blocked during evaluation, which also stalls before loading
// its result while the earlier result has not been taken; one result is held.
// rst_ni clears config to defaults, window to all ones, PD history to zero.
module line_sensor_pd_steering (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sensor_bits
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] servo_pulse, [23:12] target_pulse
  output logic        m_axis_tuser,   // [0] line_seen
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);
  import lsps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sensor_bits_i  (s_axis_tdata),
    .window_end_i   (s_axis_tlast),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .servo_pulse_o  (m_axis_tdata[11:0]),
    .target_pulse_o (m_axis_tdata[23:12]),
    .line_seen_o    (m_axis_tuser)
  );
endmodule

FILE: src/lsps_chk.sv
// Port-level checker for the line sensor PD steering block, with its bind.
module lsps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result without a closed window");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("input taken in the cycle a result was loaded");
endmodule

bind line_sensor_pd_steering lsps_chk u_lsps_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/testbench.sv
// Testbench for line_sensor_pd_steering: directed and random snapshots checked against a PD predictor.
`timescale 1ns / 1ps

module testbench;
  import lsps_pkg::*;

  typedef struct {
    logic [11:0] servo;
    logic [11:0] target;
    logic        line;
  } steer_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'hff;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = 3'd0;
  logic [11:0] cfg_data_i = 12'd0;

  line_sensor_pd_steering dut (.*);

  always #1 clk_i = ~clk_i;

  // shadow registers and block state
  int center_q, min_q, max_q, outer_q, inner_q, pgain_q, dgain_q;
  logic [7:0] win_pat;
  logic [7:0] taps [MedianTaps];
  int win_idx, held_tgt, prev_err;
  int hist [3];

  steer_word_t steer_q [$];
  int fails = 0;
  int burst_left = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  logic [31:0] cyc = 0;

  function automatic int clamp_pw(int v);
    if (v > max_q) v = max_q;
    if (v < min_q) v = min_q;
    return v;
  endfunction

  function automatic void predict_snapshot(logic [7:0] bits, logic last);
    logic [7:0] srt [MedianTaps];
    logic [7:0] key, med;
    int b, n, w, tgt, e, u;
    longint acc, s;
    steer_word_t r;
    win_pat = win_pat & bits;
    if (!last) return;
    if (win_idx < MedianTaps) taps[win_idx] = win_pat;
    win_pat = 8'hff;
    win_idx++;
    if (win_idx < MedianTaps) return;
    win_idx = 0;
    srt = taps;
    for (int a = 1; a < MedianTaps; a++) begin
      key = srt[a];
      b = a - 1;
      while (b >= 0 && srt[b] > key) begin
        srt[b+1] = srt[b];
        b--;
      end
      srt[b+1] = key;
    end
    med = srt[MedK];
    n = 0;
    w = 0;
    for (int i = 0; i < 8; i++) begin
      if (!med[i]) begin
        n++;
        if (i == 7 || i == 6 || i == 3 || i == 2) w += outer_q;
        else w -= inner_q;
      end
    end
    tgt = (n != 0) ? center_q - w / n : held_tgt;
    tgt = clamp_pw(tgt);
    held_tgt = tgt;
    e = tgt - center_q;
    u = pgain_q * e + dgain_q * (e - prev_err);
    prev_err = e;
    acc = 85 * longint'(u) + 8 * longint'(hist[0]) + 5 * longint'(hist[1])
        + 2 * longint'(hist[2]);
    s = acc / 100;
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = u;
    r.servo = 12'(clamp_pw(int'(longint'(center_q) - s)));
    r.target = 12'(tgt);
    r.line = (n != 0);
    steer_q.push_back(r);
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    steer_word_t want;
    cyc <= cyc + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (steer_q.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fails++;
      end else begin
        want = steer_q.pop_front();
        if (m_axis_tdata[11:0] !== want.servo) begin
          $error("servo_pulse exp %0d got %0d", want.servo, m_axis_tdata[11:0]);
          fails++;
        end
        if (m_axis_tdata[23:12] !== want.target) begin
          $error("target_pulse exp %0d got %0d", want.target, m_axis_tdata[23:12]);
          fails++;
        end
        if (m_axis_tuser !== want.line) begin
          $error("line_seen exp %0d got %0d", want.line, m_axis_tuser);
          fails++;
        end
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (cyc[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= (cyc[2:0] == 3'd0);
      endcase
    end
  end

  task automatic send_snapshot(logic [7:0] bits, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bits;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_snapshot(bits, last);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_CENTER: center_q = val;
      REG_MIN:    min_q = val;
      REG_MAX:    max_q = val;
      REG_OUTER:  outer_q = val[9:0];
      REG_INNER:  inner_q = val[9:0];
      REG_PGAIN:  pgain_q = val[7:0];
      REG_DGAIN:  dgain_q = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(int c, int lo, int hi, int ow, int iw, int pg, int dg);
    write_reg(REG_CENTER, 12'(c));
    write_reg(REG_MIN, 12'(lo));
    write_reg(REG_MAX, 12'(hi));
    write_reg(REG_OUTER, 12'(ow));
    write_reg(REG_INNER, 12'(iw));
    write_reg(REG_PGAIN, 12'(pg));
    write_reg(REG_DGAIN, 12'(dg));
  endtask

  function automatic logic [7:0] rand_pattern();
    case ($urandom_range(0, 5))
      0: return 8'($urandom);
      1: return ~(8'h01 << $urandom_range(0, 7));
      2: return ~(8'h03 << $urandom_range(0, 6));
      3: return 8'hff;
      4: return ~(8'h07 << $urandom_range(0, 5));
      default: return 8'($urandom) | 8'($urandom);
    endcase
  endfunction

  task automatic send_windows(int words);
    int len;
    while (words > 0) begin
      len = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) begin
        send_snapshot(8'($urandom), 1'($urandom));
        words--;
      end else begin
        for (int i = 0; i < len; i++) send_snapshot(rand_pattern(), i == len - 1);
        words -= len;
      end
    end
  endtask

  task automatic test_directed_defaults();
    logic [7:0] pats [20] = '{8'hff, 8'h7f, 8'hbf, 8'hdf, 8'hef, 8'h00, 8'h00, 8'h00,
                              8'hf7, 8'hfb, 8'hfd, 8'hfe, 8'h3f, 8'h3f, 8'hcf, 8'hcf,
                              8'hfc, 8'hf3, 8'h55, 8'haa};
    foreach (pats[i]) send_snapshot(pats[i], 1'b1);
    send_snapshot(8'hf0, 1'b0);
    send_snapshot(8'h0f, 1'b0);
    send_snapshot(8'hff, 1'b1);
    drain();
  endtask

  task automatic test_config_sweep();
    apply_setting(0, 0, 0, 0, 0, 0, 0);
    send_windows(120);
    drain();
    apply_setting(4095, 4095, 4095, 1023, 1023, 255, 255);
    send_windows(150);
    drain();
    apply_setting(2048, 0, 4095, 1023, 1023, 255, 255);
    send_windows(150);
    drain();
    apply_setting(1000, 3000, 500, 700, 200, 9, 3);
    send_windows(120);
    drain();
    apply_setting(0, 0, 4095, 1023, 0, 255, 0);
    send_windows(150);
    drain();
    apply_setting(4095, 0, 4095, 0, 1023, 0, 255);
    send_windows(150);
    drain();
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      apply_setting($urandom_range(0, 4095), $urandom_range(0, 1500),
                    $urandom_range(1200, 4095), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 255),
                    $urandom_range(0, 255));
      send_windows(120);
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    apply_setting(1210, 850, 1600, 400, 300, 1, 1);
    hold_req++;
    send_windows(200);
    drain();
  endtask

  initial begin
    center_q = 1210; min_q = 850; max_q = 1600;
    outer_q = 400; inner_q = 300; pgain_q = 1; dgain_q = 1;
    win_pat = 8'hff; win_idx = 0; held_tgt = 0; prev_err = 0;
    hist = '{0, 0, 0};
    foreach (taps[i]) taps[i] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_defaults();
    test_config_sweep();
    test_random_settings();
    test_output_backpressure();
    if (fails == 0) $display("line_sensor_pd_steering verification clean");
    else $display("line_sensor_pd_steering verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("line_sensor_pd_steering verification failed");
    $finish;
  end

endmodule
